@@ rtl/core/dual_input_ring_priority_merge_macros.svh @@
// Assertion helpers shared by the merge block.
`ifndef DUAL_INPUT_RING_PRIORITY_MERGE_MACROS_SVH
`define DUAL_INPUT_RING_PRIORITY_MERGE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DIRPM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define DIRPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/dirpm_pkg.sv @@
package dirpm_pkg;

   localparam logic [1:0] OP_PUSH_KBD   = 2'd0;
   localparam logic [1:0] OP_PUSH_REPLY = 2'd1;
   localparam logic [1:0] OP_POP        = 2'd2;
   localparam logic [1:0] OP_PEEK       = 2'd3;

   localparam logic [1:0] SRC_ANY   = 2'd0;
   localparam logic [1:0] SRC_KBD   = 2'd1;
   localparam logic [1:0] SRC_REPLY = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_push;
   } ctrl_sts_type;

endpackage

@@ rtl/core/dirpm_datapath.sv @@
module dirpm_datapath
   import dirpm_pkg::*;
#(
   parameter int RING_DEPTH = 512
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output ctrl_sts_type sts,
   input  logic [1:0]   req_opcode,
   input  logic [1:0]   req_source_select,
   input  logic [7:0]   req_data_byte,
   output logic [7:0]   rsp_result_byte,
   output logic         rsp_result_valid,
   output logic [1:0]   rsp_result_source,
   output logic         rsp_push_dropped
);

   localparam int PTR_W = $clog2(RING_DEPTH);

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] nxt;
      if (p == PTR_W'(RING_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = p + 1'b1;
      end
      return nxt;
   endfunction

   logic [7:0] kb_mem [RING_DEPTH];
   logic [7:0] rp_mem [RING_DEPTH];
   logic [7:0] kb_q_ff, rp_q_ff;

   logic [1:0] op_ff, sel_ff;
   logic [7:0] data_ff;

   logic [PTR_W-1:0] kb_wr_ff, kb_wr_in, kb_rd_ff, kb_rd_in;
   logic [PTR_W-1:0] rp_wr_ff, rp_wr_in, rp_rd_ff, rp_rd_in;

   logic       hit_ff, hit_in;
   logic [1:0] src_ff, src_in;

   logic [7:0] byte_ff, byte_in;
   logic       valid_ff, valid_in;
   logic [1:0] srco_ff, srco_in;
   logic       drop_ff, drop_in;

   logic kb_empty, rp_empty, kb_full, rp_full;
   logic kb_we, rp_we;

   assign kb_empty = (kb_wr_ff == kb_rd_ff);
   assign rp_empty = (rp_wr_ff == rp_rd_ff);
   assign kb_full  = (advance(kb_wr_ff) == kb_rd_ff);
   assign rp_full  = (advance(rp_wr_ff) == rp_rd_ff);

   assign sts.is_push = (op_ff == OP_PUSH_KBD) || (op_ff == OP_PUSH_REPLY);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         sel_ff  <= req_source_select;
         data_ff <= req_data_byte;
      end
   end

   always_comb begin
      kb_we    = 1'b0;
      rp_we    = 1'b0;
      kb_wr_in = kb_wr_ff;
      kb_rd_in = kb_rd_ff;
      rp_wr_in = rp_wr_ff;
      rp_rd_in = rp_rd_ff;
      hit_in   = hit_ff;
      src_in   = src_ff;
      if (cmd.exec) begin
         hit_in = 1'b0;
         src_in = SRC_ANY;
         unique case (op_ff)
            OP_PUSH_KBD: begin
               if (!kb_full) begin
                  kb_we    = 1'b1;
                  kb_wr_in = advance(kb_wr_ff);
               end
            end
            OP_PUSH_REPLY: begin
               if (!rp_full) begin
                  rp_we    = 1'b1;
                  rp_wr_in = advance(rp_wr_ff);
               end
            end
            OP_POP: begin
               priority if (sel_ff == SRC_ANY && !rp_empty) begin
                  hit_in   = 1'b1;
                  src_in   = SRC_REPLY;
                  rp_rd_in = advance(rp_rd_ff);
               end else if (sel_ff == SRC_ANY && !kb_empty) begin
                  hit_in   = 1'b1;
                  src_in   = SRC_KBD;
                  kb_rd_in = advance(kb_rd_ff);
               end else if (sel_ff == SRC_KBD && !kb_empty) begin
                  hit_in   = 1'b1;
                  src_in   = SRC_KBD;
                  kb_rd_in = advance(kb_rd_ff);
               end else if (sel_ff == SRC_REPLY && !rp_empty) begin
                  hit_in   = 1'b1;
                  src_in   = SRC_REPLY;
                  rp_rd_in = advance(rp_rd_ff);
               end else begin
                  hit_in = 1'b0;
               end
            end
            OP_PEEK: begin
               priority if (sel_ff == SRC_KBD && !kb_empty) begin
                  hit_in = 1'b1;
                  src_in = SRC_KBD;
               end else if (sel_ff == SRC_REPLY && !rp_empty) begin
                  hit_in = 1'b1;
                  src_in = SRC_REPLY;
               end else begin
                  hit_in = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kb_wr_ff <= '0;
         kb_rd_ff <= '0;
         rp_wr_ff <= '0;
         rp_rd_ff <= '0;
      end else begin
         kb_wr_ff <= kb_wr_in;
         kb_rd_ff <= kb_rd_in;
         rp_wr_ff <= rp_wr_in;
         rp_rd_ff <= rp_rd_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      src_ff <= src_in;
   end

   // ring stores, registered read at the head
   always_ff @(posedge clock) begin
      if (kb_we) begin
         kb_mem[kb_wr_ff] <= data_ff;
      end
      kb_q_ff <= kb_mem[kb_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (rp_we) begin
         rp_mem[rp_wr_ff] <= data_ff;
      end
      rp_q_ff <= rp_mem[rp_rd_ff];
   end

   always_comb begin
      byte_in  = byte_ff;
      valid_in = valid_ff;
      srco_in  = srco_ff;
      drop_in  = drop_ff;
      if (cmd.exec && sts.is_push) begin
         byte_in  = 8'd0;
         valid_in = 1'b0;
         srco_in  = SRC_ANY;
         drop_in  = (op_ff == OP_PUSH_KBD) ? kb_full : rp_full;
      end else if (cmd.load) begin
         valid_in = hit_ff;
         srco_in  = hit_ff ? src_ff : SRC_ANY;
         drop_in  = 1'b0;
         if (!hit_ff) begin
            byte_in = 8'd0;
         end else if (src_ff == SRC_REPLY) begin
            byte_in = rp_q_ff;
         end else begin
            byte_in = kb_q_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      valid_ff <= valid_in;
      srco_ff  <= srco_in;
      drop_ff  <= drop_in;
   end

   assign rsp_result_byte   = byte_ff;
   assign rsp_result_valid  = valid_ff;
   assign rsp_result_source = srco_ff;
   assign rsp_push_dropped  = drop_ff;

endmodule

@@ rtl/core/dirpm_controller.sv @@
`include "dual_input_ring_priority_merge_macros.svh"

module dirpm_controller
   import dirpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd,
   input  ctrl_sts_type sts
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = sts.is_push ? ST_RESP : ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      rsp_valid   = (state_ff == ST_RESP);
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.exec    = (state_ff == ST_EXEC);
      cmd.load    = (state_ff == ST_LOAD);
   end

   `DIRPM_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_valid && req_ready, state_ff == ST_EXEC)
   `DIRPM_ASSERT_NEXT(a_push_skips_load, clock, reset, cmd.exec && sts.is_push, rsp_valid)
   `DIRPM_ASSERT_NEXT(a_load_to_resp, clock, reset, cmd.load, rsp_valid && !req_ready)
   `DIRPM_ASSERT_NOW(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.capture, cmd.exec, cmd.load}))

endmodule

@@ rtl/core/dual_input_ring_priority_merge.sv @@
// A push steps through the idle, exec and resp states; a pop or peek adds a load state between exec and resp.
// A new word is accepted only in idle, after the response to the last one is taken with rsp_ready high;
// this is set by the single-word controller and the registered read of each ring store.
// Reset (synchronous, active high) clears all ring pointers and returns the controller
// to idle; ring store contents are not cleared and are read only after being written.
module dual_input_ring_priority_merge
   import dirpm_pkg::*;
#(
   parameter int RING_DEPTH = 512
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [1:0] req_source_select,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_result_byte,
   output logic       rsp_result_valid,
   output logic [1:0] rsp_result_source,
   output logic       rsp_push_dropped
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   dirpm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   dirpm_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_opcode        (req_opcode),
      .req_source_select (req_source_select),
      .req_data_byte     (req_data_byte),
      .rsp_result_byte   (rsp_result_byte),
      .rsp_result_valid  (rsp_result_valid),
      .rsp_result_source (rsp_result_source),
      .rsp_push_dropped  (rsp_push_dropped)
   );

endmodule
